### design/asrl_pkg.sv
// Shared types and constants for the aspect-scaled region layout block.
package asrl_pkg;

  localparam int unsigned ALIGN_SHIFT_DEF = 4;

  localparam int unsigned SIDE_W  = 14;
  localparam int unsigned WIDE_W  = 28;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 14;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_FIT     = 2'd1,
    MODE_FILL    = 2'd2,
    MODE_STRETCH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_SAT  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_LEFT   = 3'd1,
    CFG_TOP    = 3'd2,
    CFG_SPAN_X = 3'd3,
    CFG_SPAN_Y = 3'd4
  } cfg_idx_t;

endpackage

### design/asrl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module asrl_div #(
  parameter int unsigned DEN_W = 14,
  parameter int unsigned QUO_W = 28,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DEN_W-1:0] in_hi,
  input  logic [QUO_W-1:0] in_lo,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);

  // The partial remainder must start below the divisor so the quotient fits QUO_W bits.
  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] lo_r  [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [TAG_W-1:0] tag_r [QUO_W];
  logic             vld_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] lo_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;
    logic [QUO_W-1:0] lo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = in_hi;
      assign lo_in  = in_lo;
      assign den_in = in_den;
      assign tag_in = in_tag;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign den_in = den_r[k-1];
      assign tag_in = tag_r[k-1];
      assign vld_in = vld_r[k-1];
    end

    assign trial   = {rem_in, lo_in[QUO_W-1]};
    assign ge      = trial >= {1'b0, den_in};
    assign diff    = trial - {1'b0, den_in};
    assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign lo_nxt  = {lo_in[QUO_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      lo_r[k]  <= lo_nxt;
      den_r[k] <= den_in;
      tag_r[k] <= tag_in;
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quo   = lo_r[QUO_W-1];
  assign out_tag   = tag_r[QUO_W-1];

endmodule

### design/aspect_scale_region_layout.sv
// Top level of the aspect-scaled region layout pipeline.
//
// A request carries a source picture size (in_source_width, in_source_height)
// and is taken at a rising edge where start is high and busy is low. The block
// never stalls, so busy stays low and a new request may be issued every cycle.
// For each request, one result appears on the out_ ports from the stage F
// registers, is marked by out_valid for exactly one cycle and is taken at the
// edge that ends that cycle; the receiver must take it then.
// Most of the pipeline is two chains of 28 divider stages: the first computes
// both candidate aspect quotients in parallel, the second recovers the width
// that keeps the pre-alignment aspect after the height is aligned. Around them
// sit one input stage, one select stage, one multiply stage and three stages
// for saturation, offsets and placement. Throughput is one request per cycle.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the scale mode
// and the region origin and span; writes must only happen while no request
// is in flight, because stages A, B, E and F read the live registers.
// Reset (rst_n low, synchronous) empties the pipeline and restores the mode to
// none and the region to a 16 by 16 span at the canvas origin.
module aspect_scale_region_layout #(
  parameter int unsigned ALIGN_SHIFT = asrl_pkg::ALIGN_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [13:0]                    in_source_width,
  input  logic [13:0]                    in_source_height,
  output logic                           out_valid,
  output logic [15:0]                    out_scaled_width,
  output logic [15:0]                    out_scaled_height,
  output logic [13:0]                    out_place_x,
  output logic [13:0]                    out_place_y,
  output logic [14:0]                    out_crop_x,
  output logic [14:0]                    out_crop_y,
  output logic [15:0]                    out_draw_width,
  output logic [15:0]                    out_draw_height,
  output logic [1:0]                     out_status,
  input  logic                           cfg_we,
  input  logic [asrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asrl_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int unsigned WW = asrl_pkg::WIDE_W;
  localparam int unsigned SW = asrl_pkg::SIDE_W;
  localparam logic [WW-1:0] ALIGN_MASK = ~((WW'(1) << ALIGN_SHIFT) - WW'(1));

  // Configuration registers.
  asrl_pkg::mode_t mode_r;
  logic [12:0]     left_r;
  logic [12:0]     top_r;
  logic [SW-1:0]   span_x_r;
  logic [SW-1:0]   span_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= asrl_pkg::MODE_NONE;
      left_r   <= 13'd0;
      top_r    <= 13'd0;
      span_x_r <= SW'(16);
      span_y_r <= SW'(16);
    end else if (cfg_we) begin
      unique case (asrl_pkg::cfg_idx_t'(cfg_index))
        asrl_pkg::CFG_MODE:   mode_r   <= asrl_pkg::mode_t'(cfg_data[1:0]);
        asrl_pkg::CFG_LEFT:   left_r   <= cfg_data[12:0];
        asrl_pkg::CFG_TOP:    top_r    <= cfg_data[12:0];
        asrl_pkg::CFG_SPAN_X: span_x_r <= cfg_data;
        asrl_pkg::CFG_SPAN_Y: span_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage A: capture the request and form both cross products.
  logic          a_vld_r;
  logic [SW-1:0] a_sw_r, a_sh_r;
  logic [WW-1:0] a_p1_r, a_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_sw_r <= in_source_width;
    a_sh_r <= in_source_height;
    a_p1_r <= WW'(span_x_r) * WW'(in_source_height);
    a_p2_r <= WW'(in_source_width) * WW'(span_y_r);
  end

  // Height for the width-bound case and width for the height-bound case.
  logic          d1_vld, d2_vld;
  logic [WW-1:0] d1_quo, d2_quo;
  logic [WW-1:0] d1_tag, d2_tag;

  asrl_div #(.DEN_W(SW), .QUO_W(WW), .TAG_W(WW)) u_div_h (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (a_vld_r),
    .in_hi    ('0),
    .in_lo    (a_p1_r),
    .in_den   (a_sw_r),
    .in_tag   ({a_sw_r, a_sh_r}),
    .out_valid(d1_vld),
    .out_quo  (d1_quo),
    .out_tag  (d1_tag)
  );

  asrl_div #(.DEN_W(SW), .QUO_W(WW), .TAG_W(WW)) u_div_w (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (a_vld_r),
    .in_hi    ('0),
    .in_lo    (a_p2_r),
    .in_den   (a_sh_r),
    .in_tag   ({a_sw_r, a_sh_r}),
    .out_valid(d2_vld),
    .out_quo  (d2_quo),
    .out_tag  (d2_tag)
  );

  // Stage B: pick the pre-alignment size by mode and align the height.
  logic [SW-1:0] b_sw, b_sh;
  logic [WW-1:0] b_w_nxt, b_h_nxt;
  logic          b_deg_nxt;
  logic          b_vld_r, b_zero_r;
  logic [WW-1:0] b_w_r, b_h_r, b_ha_r;

  assign b_sw = d1_tag[2*SW-1:SW];
  assign b_sh = d2_tag[SW-1:0];

  always_comb begin
    b_w_nxt   = WW'(span_x_r);
    b_h_nxt   = WW'(span_y_r);
    b_deg_nxt = 1'b0;
    case (mode_r)
      asrl_pkg::MODE_NONE: begin
        b_w_nxt = WW'(b_sw);
        b_h_nxt = WW'(b_sh);
      end
      asrl_pkg::MODE_FIT: begin
        b_deg_nxt = (b_sw == '0) || (b_sh == '0);
        if (d1_quo > WW'(span_y_r)) begin
          b_w_nxt = d2_quo;
        end else begin
          b_h_nxt = d1_quo;
        end
      end
      asrl_pkg::MODE_FILL: begin
        b_deg_nxt = (b_sw == '0) || (b_sh == '0);
        if (d1_quo < WW'(span_y_r)) begin
          b_w_nxt = d2_quo;
        end else begin
          b_h_nxt = d1_quo;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= d1_vld && d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_w_r    <= b_w_nxt;
    b_h_r    <= b_h_nxt;
    b_ha_r   <= b_h_nxt & ALIGN_MASK;
    b_zero_r <= b_deg_nxt || (b_h_nxt == '0);
  end

  // Stage C: width times aligned height.
  logic            c_vld_r, c_zero_r;
  logic [2*WW-1:0] c_prod_r;
  logic [WW-1:0]   c_h_r, c_ha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c_prod_r <= (2*WW)'(b_w_r) * (2*WW)'(b_ha_r);
    c_h_r    <= b_h_r;
    c_ha_r   <= b_ha_r;
    c_zero_r <= b_zero_r;
  end

  // The quotient never exceeds the width, so it fits the wide field.
  logic          d3_vld;
  logic [WW-1:0] d3_quo;
  logic [WW:0]   d3_tag;

  asrl_div #(.DEN_W(WW), .QUO_W(WW), .TAG_W(WW + 1)) u_div_wa (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (c_vld_r),
    .in_hi    (c_prod_r[2*WW-1:WW]),
    .in_lo    (c_prod_r[WW-1:0]),
    .in_den   (c_h_r),
    .in_tag   ({c_zero_r, c_ha_r}),
    .out_valid(d3_vld),
    .out_quo  (d3_quo),
    .out_tag  (d3_tag)
  );

  // Stage D: align the width and saturate both sides.
  logic [WW-1:0]     d_wa, d_ha;
  logic              d_sat_w, d_sat_h;
  logic              d_vld_r, d_zero_r;
  logic [15:0]       d_iw_r, d_ih_r;
  asrl_pkg::status_t d_status_r;

  assign d_wa    = d3_quo & ALIGN_MASK;
  assign d_ha    = d3_tag[WW-1:0];
  assign d_sat_w = d_wa > WW'(16'hFFFF);
  assign d_sat_h = d_ha > WW'(16'hFFFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_iw_r     <= d_sat_w ? 16'hFFFF : d_wa[15:0];
    d_ih_r     <= d_sat_h ? 16'hFFFF : d_ha[15:0];
    d_status_r <= (d_sat_w || d_sat_h) ? asrl_pkg::STATUS_SAT : asrl_pkg::STATUS_OK;
    d_zero_r   <= d3_tag[WW];
  end

  // Stage E: half differences give the centring offsets and crops.
  logic              e_gtx, e_gty, e_ltx, e_lty;
  logic [15:0]       e_adx, e_ady;
  logic [14:0]       e_hx, e_hy;
  logic [14:0]       e_offx_nxt, e_offy_nxt, e_cx_nxt, e_cy_nxt;
  logic              e_vld_r, e_zero_r;
  logic [14:0]       e_offx_r, e_offy_r, e_cx_r, e_cy_r;
  logic [15:0]       e_iw_r, e_ih_r;
  asrl_pkg::status_t e_status_r;

  assign e_gtx = 16'(span_x_r) > d_iw_r;
  assign e_gty = 16'(span_y_r) > d_ih_r;
  assign e_ltx = 16'(span_x_r) < d_iw_r;
  assign e_lty = 16'(span_y_r) < d_ih_r;
  assign e_adx = e_gtx ? 16'(span_x_r) - d_iw_r : d_iw_r - 16'(span_x_r);
  assign e_ady = e_gty ? 16'(span_y_r) - d_ih_r : d_ih_r - 16'(span_y_r);
  assign e_hx  = e_adx[15:1];
  assign e_hy  = e_ady[15:1];

  always_comb begin
    e_offx_nxt = '0;
    e_offy_nxt = '0;
    e_cx_nxt   = '0;
    e_cy_nxt   = '0;
    case (mode_r)
      asrl_pkg::MODE_NONE: begin
        if (e_gtx) begin
          e_offx_nxt = e_hx;
        end else begin
          e_cx_nxt = e_hx;
        end
        if (e_gty) begin
          e_offy_nxt = e_hy;
        end else begin
          e_cy_nxt = e_hy;
        end
      end
      asrl_pkg::MODE_FIT: begin
        e_offx_nxt = e_hx;
        e_offy_nxt = e_hy;
      end
      asrl_pkg::MODE_FILL: begin
        // Only one axis is cropped, width first.
        if (e_ltx) begin
          e_cx_nxt = e_hx;
        end else if (e_lty) begin
          e_cy_nxt = e_hy;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e_offx_r   <= e_offx_nxt;
    e_offy_r   <= e_offy_nxt;
    e_cx_r     <= e_cx_nxt;
    e_cy_r     <= e_cy_nxt;
    e_iw_r     <= d_iw_r;
    e_ih_r     <= d_ih_r;
    e_status_r <= d_status_r;
    e_zero_r   <= d_zero_r;
  end

  // Stage F: canvas placement with saturation and drawn size clipped to the region.
  logic [15:0] f_px, f_py;
  logic [16:0] f_endx, f_endy;
  logic [15:0] f_dw, f_dh;
  logic        out_valid_r;
  logic [15:0] scaled_width_r, scaled_height_r, draw_width_r, draw_height_r;
  logic [13:0] place_x_r, place_y_r;
  logic [14:0] crop_x_r, crop_y_r;
  logic [1:0]  status_r;

  assign f_px   = 16'(left_r) + 16'(e_offx_r);
  assign f_py   = 16'(top_r) + 16'(e_offy_r);
  assign f_endx = 17'(e_offx_r) + 17'(e_iw_r);
  assign f_endy = 17'(e_offy_r) + 17'(e_ih_r);

  always_comb begin
    f_dw = e_iw_r;
    if (f_endx > 17'(span_x_r)) begin
      f_dw = (16'(e_offx_r) > 16'(span_x_r)) ? 16'd0 : 16'(span_x_r) - 16'(e_offx_r);
    end
    f_dh = e_ih_r;
    if (f_endy > 17'(span_y_r)) begin
      f_dh = (16'(e_offy_r) > 16'(span_y_r)) ? 16'd0 : 16'(span_y_r) - 16'(e_offy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e_zero_r) begin
      scaled_width_r  <= '0;
      scaled_height_r <= '0;
      place_x_r       <= '0;
      place_y_r       <= '0;
      crop_x_r        <= '0;
      crop_y_r        <= '0;
      draw_width_r    <= '0;
      draw_height_r   <= '0;
      status_r        <= asrl_pkg::STATUS_ZERO;
    end else begin
      scaled_width_r  <= e_iw_r;
      scaled_height_r <= e_ih_r;
      place_x_r       <= (f_px > 16'd16383) ? 14'd16383 : f_px[13:0];
      place_y_r       <= (f_py > 16'd16383) ? 14'd16383 : f_py[13:0];
      crop_x_r        <= e_cx_r;
      crop_y_r        <= e_cy_r;
      draw_width_r    <= f_dw;
      draw_height_r   <= f_dh;
      status_r        <= e_status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scaled_width  = scaled_width_r;
  assign out_scaled_height = scaled_height_r;
  assign out_place_x       = place_x_r;
  assign out_place_y       = place_y_r;
  assign out_crop_x        = crop_x_r;
  assign out_crop_y        = crop_y_r;
  assign out_draw_width    = draw_width_r;
  assign out_draw_height   = draw_height_r;
  assign out_status        = status_r;

endmodule

### design/asrl_chk.sv
// Port-level checker for the aspect-scaled region layout block, with its bind.
module asrl_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [15:0] out_scaled_width,
  input logic [15:0] out_scaled_height,
  input logic [13:0] out_place_x,
  input logic [13:0] out_place_y,
  input logic [15:0] out_draw_width,
  input logic [15:0] out_draw_height,
  input logic [1:0]  out_status
);

  // No result may come out of a pipeline that reset has just emptied.
  a_no_result_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == asrl_pkg::STATUS_OK) ||
      (out_status == asrl_pkg::STATUS_ZERO) || (out_status == asrl_pkg::STATUS_SAT))
    else $error("undefined status code");

  a_zero_height_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == asrl_pkg::STATUS_ZERO) |->
      (out_scaled_width == '0) && (out_scaled_height == '0) &&
      (out_place_x == '0) && (out_place_y == '0) &&
      (out_draw_width == '0) && (out_draw_height == '0))
    else $error("zero height result carries nonzero fields");

  a_drawn_within_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_draw_width <= out_scaled_width) &&
      (out_draw_height <= out_scaled_height))
    else $error("drawn size exceeds scaled size");

endmodule

bind aspect_scale_region_layout asrl_chk u_asrl_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_scaled_width (out_scaled_width),
  .out_scaled_height(out_scaled_height),
  .out_place_x      (out_place_x),
  .out_place_y      (out_place_y),
  .out_draw_width   (out_draw_width),
  .out_draw_height  (out_draw_height),
  .out_status       (out_status)
);
